// ----- hw/rtl/ipv4p_pkg.sv -----
// Shared types and constants for the IPv4 header parser.
`timescale 1ns / 1ps

package ipv4p_pkg;

  // Result status, in the order the checks are applied.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_IHL   = 3'd2,
    ST_BAD_CSUM  = 3'd3,
    ST_BAD_TOTAL = 3'd4,
    ST_TTL_ZERO  = 3'd5,
    ST_BAD_VER   = 3'd6
  } status_t;

  // Class of the next-layer protocol.
  typedef enum logic [2:0] {
    NP_NONE = 3'd0,
    NP_TCP  = 3'd1,
    NP_ICMP = 3'd2,
    NP_UDP  = 3'd3,
    NP_IGMP = 3'd4,
    NP_EGP  = 3'd5
  } proto_class_t;

  localparam logic [7:0] IP_PROTO_ICMP = 8'd1;
  localparam logic [7:0] IP_PROTO_IGMP = 8'd2;
  localparam logic [7:0] IP_PROTO_TCP  = 8'd6;
  localparam logic [7:0] IP_PROTO_EGP  = 8'd8;
  localparam logic [7:0] IP_PROTO_UDP  = 8'd17;

  localparam logic [3:0]  HDR_VERSION  = 4'd4;
  localparam logic [5:0]  MIN_HDR_LEN  = 6'd20;
  localparam logic [5:0]  CSUM_END     = 6'd60;
  localparam logic [15:0] CSUM_GOOD    = 16'hffff;

  // Byte count as carried to the back end, clamped to this many bits.
  localparam int REC_COUNT_BITS = 17;

  // Everything the back end needs to know about one finished packet.
  typedef struct packed {
    logic [REC_COUNT_BITS-1:0] byte_count;
    logic                      sum_ok;
    logic [3:0]                version;
    logic [5:0]                header_len;
    logic [7:0]                tos;
    logic [15:0]               total_length;
    logic [15:0]               ident;
    logic [15:0]               frag_word;
    logic [7:0]                ttl;
    logic [7:0]                proto;
    logic [31:0]               src_addr;
    logic [31:0]               dst_addr;
  } pkt_rec_t;

endpackage

// ----- hw/rtl/ipv4p_front.sv -----
// Front end: takes packet bytes, captures header fields and sums the header.
`timescale 1ns / 1ps

module ipv4p_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  input  logic              byte_last,
  output ipv4p_pkg::pkt_rec_t rec,
  output logic              rec_push
);

  logic [COUNT_BITS-1:0] byte_count;
  logic [COUNT_BITS-1:0] byte_count_next;
  logic [15:0]           sum_acc;
  logic [15:0]           sum_acc_next;
  logic [7:0]            high_byte_hold;
  logic [7:0]            high_byte_hold_next;
  logic [7:0]            version_ihl;
  logic [7:0]            version_ihl_next;
  logic [7:0]            tos_reg;
  logic [7:0]            tos_reg_next;
  logic [15:0]           total_length;
  logic [15:0]           total_length_next;
  logic [15:0]           ident_reg;
  logic [15:0]           ident_reg_next;
  logic [15:0]           frag_word;
  logic [15:0]           frag_word_next;
  logic [7:0]            ttl_reg;
  logic [7:0]            ttl_reg_next;
  logic [7:0]            proto_reg;
  logic [7:0]            proto_reg_next;
  logic [31:0]           src_reg;
  logic [31:0]           src_reg_next;
  logic [31:0]           dst_reg;
  logic [31:0]           dst_reg_next;

  logic                  in_header_window;
  logic [5:0]            off;
  logic [5:0]            hl;
  logic [16:0]           word_sum;
  logic [32:0]           count_wide;

  // Offsets 0..63 are the only ones that matter for capture and checksum.
  assign in_header_window = (byte_count >> 6) == '0;
  assign off              = byte_count[5:0];

  always_comb begin
    version_ihl_next    = version_ihl;
    tos_reg_next        = tos_reg;
    total_length_next   = total_length;
    ident_reg_next      = ident_reg;
    frag_word_next      = frag_word;
    ttl_reg_next        = ttl_reg;
    proto_reg_next      = proto_reg;
    src_reg_next        = src_reg;
    dst_reg_next        = dst_reg;
    high_byte_hold_next = high_byte_hold;
    sum_acc_next        = sum_acc;
    word_sum            = {1'b0, sum_acc} + {1'b0, high_byte_hold, byte_data};

    if (in_header_window) begin
      case (off)
        6'd0: version_ihl_next = byte_data;
        6'd1: tos_reg_next = byte_data;
        6'd2, 6'd3: total_length_next = {total_length[7:0], byte_data};
        6'd4, 6'd5: ident_reg_next = {ident_reg[7:0], byte_data};
        6'd6, 6'd7: frag_word_next = {frag_word[7:0], byte_data};
        6'd8: ttl_reg_next = byte_data;
        6'd9: proto_reg_next = byte_data;
        6'd12, 6'd13, 6'd14, 6'd15: src_reg_next = {src_reg[23:0], byte_data};
        6'd16, 6'd17, 6'd18, 6'd19: dst_reg_next = {dst_reg[23:0], byte_data};
        default: ;
      endcase
    end

    // The header length in force includes the byte just taken.
    hl = {version_ihl_next[3:0], 2'b00};

    if (in_header_window && (off < ipv4p_pkg::CSUM_END)) begin
      if (!off[0]) begin
        high_byte_hold_next = byte_data;
      end else if (off < hl) begin
        // End-around carry; the folded sum never exceeds 16 bits.
        sum_acc_next = word_sum[15:0] + {15'd0, word_sum[16]};
      end
    end

    if (byte_count == '1) begin
      byte_count_next = byte_count;
    end else begin
      byte_count_next = byte_count + 1'b1;
    end
  end

  assign count_wide = 33'(byte_count_next);

  always_comb begin
    if (count_wide > 33'((1 << ipv4p_pkg::REC_COUNT_BITS) - 1)) begin
      rec.byte_count = '1;
    end else begin
      rec.byte_count = count_wide[ipv4p_pkg::REC_COUNT_BITS-1:0];
    end
    rec.sum_ok       = sum_acc_next == ipv4p_pkg::CSUM_GOOD;
    rec.version      = version_ihl_next[7:4];
    rec.header_len   = hl;
    rec.tos          = tos_reg_next;
    rec.total_length = total_length_next;
    rec.ident        = ident_reg_next;
    rec.frag_word    = frag_word_next;
    rec.ttl          = ttl_reg_next;
    rec.proto        = proto_reg_next;
    rec.src_addr     = src_reg_next;
    rec.dst_addr     = dst_reg_next;
  end

  assign rec_push = byte_valid && byte_last;

  always_ff @(posedge clk) begin
    if (rst || rec_push) begin
      byte_count     <= '0;
      sum_acc        <= '0;
      high_byte_hold <= '0;
      version_ihl    <= '0;
      tos_reg        <= '0;
      total_length   <= '0;
      ident_reg      <= '0;
      frag_word      <= '0;
      ttl_reg        <= '0;
      proto_reg      <= '0;
      src_reg        <= '0;
      dst_reg        <= '0;
    end else if (byte_valid) begin
      byte_count     <= byte_count_next;
      sum_acc        <= sum_acc_next;
      high_byte_hold <= high_byte_hold_next;
      version_ihl    <= version_ihl_next;
      tos_reg        <= tos_reg_next;
      total_length   <= total_length_next;
      ident_reg      <= ident_reg_next;
      frag_word      <= frag_word_next;
      ttl_reg        <= ttl_reg_next;
      proto_reg      <= proto_reg_next;
      src_reg        <= src_reg_next;
      dst_reg        <= dst_reg_next;
    end
  end

endmodule

// ----- hw/rtl/ipv4p_queue.sv -----
// Two-entry queue of packet records between the front and back ends.
`timescale 1ns / 1ps

module ipv4p_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ipv4p_pkg::pkt_rec_t push_rec,
  input  logic                pop,
  output ipv4p_pkg::pkt_rec_t head_rec,
  output logic                empty,
  output logic                full
);

  ipv4p_pkg::pkt_rec_t slots [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          fill;

  assign empty    = fill == 2'd0;
  assign full     = fill == 2'd2;
  assign head_rec = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

endmodule

// ----- hw/rtl/ipv4p_back.sv -----
// Back end: runs the header checks on one record and holds the result.
`timescale 1ns / 1ps

module ipv4p_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                checksum_enable,
  input  ipv4p_pkg::pkt_rec_t rec,
  input  logic                rec_valid,
  output logic                rec_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [135:0]        res_data,
  output logic [5:0]          res_user
);

  ipv4p_pkg::status_t      status;
  ipv4p_pkg::proto_class_t np;
  ipv4p_pkg::proto_class_t proto_cls;
  logic [16:0]             hl_ext;
  logic [16:0]             after_hdr;
  logic [15:0]             want;
  logic [15:0]             plen;
  logic                    hl_fits;
  logic                    frag;
  logic [1:0]              fcount;

  assign hl_ext    = {11'd0, rec.header_len};
  assign hl_fits   = hl_ext <= rec.byte_count;
  assign after_hdr = rec.byte_count - hl_ext;
  assign want      = rec.total_length - {10'd0, rec.header_len};

  always_comb begin
    if (rec.byte_count <= 17'(ipv4p_pkg::MIN_HDR_LEN)) begin
      status = ipv4p_pkg::ST_SHORT;
    end else if (rec.header_len < ipv4p_pkg::MIN_HDR_LEN) begin
      status = ipv4p_pkg::ST_BAD_IHL;
    end else if (!hl_fits) begin
      status = ipv4p_pkg::ST_SHORT;
    end else if (checksum_enable && !rec.sum_ok) begin
      status = ipv4p_pkg::ST_BAD_CSUM;
    end else if (rec.total_length < {10'd0, rec.header_len}) begin
      status = ipv4p_pkg::ST_BAD_TOTAL;
    end else if (rec.ttl == 8'd0) begin
      status = ipv4p_pkg::ST_TTL_ZERO;
    end else if (rec.version != ipv4p_pkg::HDR_VERSION) begin
      status = ipv4p_pkg::ST_BAD_VER;
    end else begin
      status = ipv4p_pkg::ST_OK;
    end
  end

  always_comb begin
    plen = 16'd0;
    if ((rec.header_len >= ipv4p_pkg::MIN_HDR_LEN) && hl_fits &&
        (rec.total_length >= {10'd0, rec.header_len})) begin
      if (after_hdr < {1'b0, want}) begin
        plen = after_hdr[15:0];
      end else begin
        plen = want;
      end
    end
  end

  always_comb begin
    case (rec.proto)
      ipv4p_pkg::IP_PROTO_TCP:  proto_cls = ipv4p_pkg::NP_TCP;
      ipv4p_pkg::IP_PROTO_ICMP: proto_cls = ipv4p_pkg::NP_ICMP;
      ipv4p_pkg::IP_PROTO_UDP:  proto_cls = ipv4p_pkg::NP_UDP;
      ipv4p_pkg::IP_PROTO_IGMP: proto_cls = ipv4p_pkg::NP_IGMP;
      ipv4p_pkg::IP_PROTO_EGP:  proto_cls = ipv4p_pkg::NP_EGP;
      default:                  proto_cls = ipv4p_pkg::NP_NONE;
    endcase
  end

  // A fragment is anything with more-fragments set or a nonzero offset.
  assign frag   = rec.frag_word[13] || (rec.frag_word[12:0] != 13'd0);
  assign np     = ((status == ipv4p_pkg::ST_OK) && !frag) ? proto_cls : ipv4p_pkg::NP_NONE;
  assign fcount = {1'b0, rec.frag_word[15]} + {1'b0, rec.frag_word[14]} +
                  {1'b0, rec.frag_word[13]};

  // The output register is reloaded whenever it is empty or being drained.
  assign rec_pop = rec_valid && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rec_pop) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      res_user <= {status, np};
      res_data <= {rec.ident, rec.tos, rec.ttl, fcount, rec.frag_word[15:13],
                   rec.frag_word[12:0], plen, rec.header_len, rec.dst_addr,
                   rec.src_addr};
    end
  end

endmodule

// ----- hw/rtl/ipv4_header_parser.sv -----
// Top level of the IPv4 header parser.
`timescale 1ns / 1ps

// The packet enters on the s_ stream, one byte per transaction, header first,
// with s_tlast set on the final byte. Every other byte produces nothing; the
// final byte produces exactly one result transaction on the m_ stream, which
// carries the status and next-protocol class in m_tuser and the captured
// header fields in m_tdata.
//
// Throughput is one byte per cycle while s_tready is high; the per-byte work
// is a field capture and one 16-bit ones-complement add in the front end. The
// s_tlast byte writes the record into the queue, which loads the back end's
// output register, raising m_tvalid, once that register is empty or drained.
//
// The front end hands each finished packet to a two-entry record queue, so
// a stalled m_tready only holds up input once the output register and both
// queue entries are occupied; s_tready then drops until the back end drains.
//
// Reset clears all per-packet state, empties the queue and the output, and
// sets checksum checking on. cfg_we writes cfg_wdata into the checksum
// enable; it is meant to be written only while no packet is in flight.
module ipv4_header_parser #(
  parameter int COUNT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,    // checksum_enable
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,      // data_byte
  input  logic         s_tlast,      // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] source_addr, [63:32] dest_addr, [69:64] header_len,
  // [85:70] payload_len, [98:86] frag_offset, [101:99] frag_flags,
  // [103:102] flag_count, [111:104] time_to_live, [119:112] service_type,
  // [135:120] ident
  output logic [135:0] m_tdata,
  // [2:0] next_proto, [5:3] status
  output logic [5:0]   m_tuser
);

  logic                checksum_enable;
  logic                byte_accept;
  logic                rec_push;
  logic                rec_pop;
  logic                q_empty;
  logic                q_full;
  ipv4p_pkg::pkt_rec_t front_rec;
  ipv4p_pkg::pkt_rec_t head_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_enable <= 1'b1;
    end else if (cfg_we) begin
      checksum_enable <= cfg_wdata;
    end
  end

  // A full queue stops all input until the back end frees a slot.
  assign s_tready    = !q_full;
  assign byte_accept = s_tvalid && s_tready;

  ipv4p_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_accept),
    .byte_data (s_tdata),
    .byte_last (s_tlast),
    .rec       (front_rec),
    .rec_push  (rec_push)
  );

  ipv4p_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (rec_push),
    .push_rec(front_rec),
    .pop     (rec_pop),
    .head_rec(head_rec),
    .empty   (q_empty),
    .full    (q_full)
  );

  ipv4p_back u_back (
    .clk            (clk),
    .rst            (rst),
    .checksum_enable(checksum_enable),
    .rec            (head_rec),
    .rec_valid      (!q_empty),
    .rec_pop        (rec_pop),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res_data       (m_tdata),
    .res_user       (m_tuser)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the IPv4 header parser.
`timescale 1ns / 1ps

// The testbench sends IPv4 packets into the parser one byte per transaction
// and predicts each result in step with the byte stream. The monitor watches
// both streams at every rising edge. Each byte accepted on the s_ side goes
// through a local copy of the parser's front end: byte count, field capture
// and a ones-complement sum of the header words. When the byte carries
// tlast, the predicted result is queued. Each result accepted on the m_ side
// is unpacked and compared, field by field, with the oldest queued
// prediction.
//
// The stimulus runs as a sequence of named tests:
//   - Every protocol class and the extreme header field values.
//   - Packet and header length corner cases, including truncated headers.
//   - The remaining header checks, in the order the parser applies them.
//   - Fragments, flag bits and the fragment offset extremes.
//   - Checksum checking switched off and on again.
//   - Random traffic, mostly well-formed packets, plus corrupted, truncated
//     and pure noise packets, with the checksum enable changing between
//     groups.
// Both streams idle at random. Most gaps are short and a few are long. Some
// stretches run with no gaps at all. The checksum enable is only written
// once every predicted result has come out and the pipeline has drained.
module tb_top;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 7;
  // Extra wait after the last predicted result, as slack for the pipeline.
  localparam int DRAIN_CYCLES   = 8;
  // Cycles with no transaction on either stream before the run is stopped.
  localparam int WATCHDOG_LIMIT = 2000;
  // Byte total for the whole run that random traffic tops up to.
  localparam int ITEM_TARGET    = 600;
  localparam int RANDOM_PKTS    = 8;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic         cfg_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;
  logic [5:0]   m_tuser;

  ipv4_header_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // One parsed packet as the parser reports it.
  typedef struct {
    ipv4p_pkg::proto_class_t np;
    ipv4p_pkg::status_t      st;
    logic [31:0]             src;
    logic [31:0]             dst;
    logic [5:0]              hlen;
    logic [15:0]             plen;
    logic [12:0]             foff;
    logic [2:0]              fflags;
    logic [1:0]              fcnt;
    logic [7:0]              ttl;
    logic [7:0]              tos;
    logic [15:0]             ident;
  } hdr_result_t;

  // Header fields used to build a stimulus packet.
  typedef struct {
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  tos;
    logic [15:0] total;
    logic [15:0] ident;
    logic [2:0]  flags;
    logic [12:0] foff;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic        bad_csum;
  } hdr_fields_t;

  // Local copy of the parser's per-packet state and its register.
  logic        hp_csum_en;
  logic [15:0] hp_count;
  logic [15:0] hp_sum;
  logic [7:0]  hp_hold;
  logic [7:0]  hp_vihl;
  logic [7:0]  hp_tos;
  logic [15:0] hp_total;
  logic [15:0] hp_ident;
  logic [15:0] hp_frag;
  logic [7:0]  hp_ttl;
  logic [7:0]  hp_proto;
  logic [31:0] hp_src;
  logic [31:0] hp_dst;

  hdr_result_t parsed_headers[$];
  logic [7:0]  pkt_bytes[$];
  int          mismatch_count = 0;
  int          sent_bytes = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  bit          gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Gap length for either stream: mostly none, often short, rarely long.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_parse_state();
    hp_count = '0;
    hp_sum   = '0;
    hp_hold  = '0;
    hp_vihl  = '0;
    hp_tos   = '0;
    hp_total = '0;
    hp_ident = '0;
    hp_frag  = '0;
    hp_ttl   = '0;
    hp_proto = '0;
    hp_src   = '0;
    hp_dst   = '0;
  endtask

  // Advances the local parser by one accepted byte. On the last byte of a
  // packet, the predicted result is queued and the packet state is cleared.
  task automatic parse_byte(input logic [7:0] b, input logic lst);
    int          off;
    int          hl;
    int          n;
    int          plen;
    logic [16:0] acc;
    logic        frag;
    hdr_result_t r;
    off = hp_count;
    hl  = int'(hp_vihl[3:0]) * 4;
    case (off)
      0:              hp_vihl  = b;
      1:              hp_tos   = b;
      2, 3:           hp_total = {hp_total[7:0], b};
      4, 5:           hp_ident = {hp_ident[7:0], b};
      6, 7:           hp_frag  = {hp_frag[7:0], b};
      8:              hp_ttl   = b;
      9:              hp_proto = b;
      12, 13, 14, 15: hp_src   = {hp_src[23:0], b};
      16, 17, 18, 19: hp_dst   = {hp_dst[23:0], b};
      default: ;
    endcase
    if (off == 0) hl = int'(b[3:0]) * 4;
    // Only words that lie wholly inside the header, and within the first
    // 60 bytes, enter the checksum.
    if (off < int'(ipv4p_pkg::CSUM_END)) begin
      if (off % 2 == 0) begin
        hp_hold = b;
      end else if (off < hl) begin
        acc    = {1'b0, hp_sum} + {1'b0, hp_hold, b};
        hp_sum = acc[15:0] + acc[16];
      end
    end
    // The byte count saturates instead of wrapping.
    if (hp_count != 16'hffff) hp_count = hp_count + 16'd1;
    if (lst) begin
      n = hp_count;
      if (n <= int'(ipv4p_pkg::MIN_HDR_LEN)) r.st = ipv4p_pkg::ST_SHORT;
      else if (hl < int'(ipv4p_pkg::MIN_HDR_LEN)) r.st = ipv4p_pkg::ST_BAD_IHL;
      else if (hl > n) r.st = ipv4p_pkg::ST_SHORT;
      else if (hp_csum_en && hp_sum != ipv4p_pkg::CSUM_GOOD) r.st = ipv4p_pkg::ST_BAD_CSUM;
      else if (int'(hp_total) < hl) r.st = ipv4p_pkg::ST_BAD_TOTAL;
      else if (hp_ttl == 8'd0) r.st = ipv4p_pkg::ST_TTL_ZERO;
      else if (hp_vihl[7:4] != ipv4p_pkg::HDR_VERSION) r.st = ipv4p_pkg::ST_BAD_VER;
      else r.st = ipv4p_pkg::ST_OK;

      plen = 0;
      if (hl >= int'(ipv4p_pkg::MIN_HDR_LEN) && hl <= n && int'(hp_total) >= hl) begin
        plen = int'(hp_total) - hl;
        if (n - hl < plen) plen = n - hl;
      end

      // A fragment is anything with MF set or a nonzero offset.
      frag = hp_frag[13] || (hp_frag[12:0] != 13'd0);
      r.np = ipv4p_pkg::NP_NONE;
      if (r.st == ipv4p_pkg::ST_OK && !frag) begin
        case (hp_proto)
          ipv4p_pkg::IP_PROTO_TCP:  r.np = ipv4p_pkg::NP_TCP;
          ipv4p_pkg::IP_PROTO_ICMP: r.np = ipv4p_pkg::NP_ICMP;
          ipv4p_pkg::IP_PROTO_UDP:  r.np = ipv4p_pkg::NP_UDP;
          ipv4p_pkg::IP_PROTO_IGMP: r.np = ipv4p_pkg::NP_IGMP;
          ipv4p_pkg::IP_PROTO_EGP:  r.np = ipv4p_pkg::NP_EGP;
          default:                  r.np = ipv4p_pkg::NP_NONE;
        endcase
      end
      r.src    = hp_src;
      r.dst    = hp_dst;
      r.hlen   = hl[5:0];
      r.plen   = plen[15:0];
      r.foff   = hp_frag[12:0];
      r.fflags = hp_frag[15:13];
      r.fcnt   = 2'($countones(hp_frag[15:13]));
      r.ttl    = hp_ttl;
      r.tos    = hp_tos;
      r.ident  = hp_ident;
      parsed_headers.push_back(r);
      clear_parse_state();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
               exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Compares one result transaction with the oldest prediction.
  task automatic check_header_result();
    hdr_result_t e;
    if (parsed_headers.size() == 0) begin
      $display("%0t: result transaction with nothing predicted, tdata 0x%0h tuser 0x%0h",
               $time, m_tdata, m_tuser);
      mismatch_count++;
    end else begin
      e = parsed_headers.pop_front();
      check_field("next_proto",   32'(e.np),     32'(m_tuser[2:0]));
      check_field("status",       32'(e.st),     32'(m_tuser[5:3]));
      check_field("source_addr",  e.src,         m_tdata[31:0]);
      check_field("dest_addr",    e.dst,         m_tdata[63:32]);
      check_field("header_len",   32'(e.hlen),   32'(m_tdata[69:64]));
      check_field("payload_len",  32'(e.plen),   32'(m_tdata[85:70]));
      check_field("frag_offset",  32'(e.foff),   32'(m_tdata[98:86]));
      check_field("frag_flags",   32'(e.fflags), 32'(m_tdata[101:99]));
      check_field("flag_count",   32'(e.fcnt),   32'(m_tdata[103:102]));
      check_field("time_to_live", 32'(e.ttl),    32'(m_tdata[111:104]));
      check_field("service_type", 32'(e.tos),    32'(m_tdata[119:112]));
      check_field("ident",        32'(e.ident),  32'(m_tdata[135:120]));
    end
  endtask

  // Monitor: both streams are sampled at the edge, before any new drive
  // takes effect, so a transaction is seen exactly when the parser takes it.
  // The local parser state is cleared while reset is held.
  always @(posedge clk) begin
    if (rst) begin
      clear_parse_state();
    end else begin
      if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_header_result();
    end
  end

  // The result side stalls at random with the same gap profile.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready   <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // The watchdog stops a run in which neither stream moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one byte. tvalid stays high between back-to-back bytes and is
  // only lowered when a gap follows.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
  endtask

  // Sends the first cnt bytes of the built packet, tlast on the final one.
  task automatic send_packet(input int cnt);
    for (int i = 0; i < cnt; i++) send_byte(pkt_bytes[i], i == cnt - 1);
  endtask

  // Lowers tvalid and waits until every predicted result is out and the
  // pipeline has had time to settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (parsed_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_checksum(input logic en);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we     <= 1'b0;
    hp_csum_en = en;
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 6))
      0:       return ipv4p_pkg::IP_PROTO_ICMP;
      1:       return ipv4p_pkg::IP_PROTO_IGMP;
      2:       return ipv4p_pkg::IP_PROTO_TCP;
      3:       return ipv4p_pkg::IP_PROTO_EGP;
      4:       return ipv4p_pkg::IP_PROTO_UDP;
      default: return 8'($urandom);
    endcase
  endfunction

  // A well-formed header with random content. Callers set the total length.
  function automatic hdr_fields_t random_header();
    hdr_fields_t h;
    h.ver      = ipv4p_pkg::HDR_VERSION;
    h.ihl      = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    h.tos      = 8'($urandom);
    h.total    = 16'd0;
    h.ident    = 16'($urandom);
    h.flags    = 3'($urandom);
    h.foff     = 13'($urandom);
    // Most packets are not fragments.
    if ($urandom_range(0, 9) < 7) begin
      h.flags[0] = 1'b0;
      h.foff     = 13'd0;
    end
    h.ttl      = 8'($urandom_range(1, 255));
    h.proto    = pick_proto();
    h.src      = $urandom;
    h.dst      = $urandom;
    h.bad_csum = 1'b0;
    return h;
  endfunction

  // Builds header, options and plen payload bytes into pkt_bytes. The
  // checksum field is set so that the header words sum to all ones, then
  // corrupted if asked.
  task automatic build_packet(input hdr_fields_t h, input int plen);
    int          hl;
    int          words_end;
    logic [31:0] s;
    logic [15:0] ck;
    words_end = int'(h.ihl) * 4;
    hl = (words_end < int'(ipv4p_pkg::MIN_HDR_LEN)) ? int'(ipv4p_pkg::MIN_HDR_LEN) :
         words_end;
    pkt_bytes.delete();
    pkt_bytes.push_back({h.ver, h.ihl});
    pkt_bytes.push_back(h.tos);
    pkt_bytes.push_back(h.total[15:8]);
    pkt_bytes.push_back(h.total[7:0]);
    pkt_bytes.push_back(h.ident[15:8]);
    pkt_bytes.push_back(h.ident[7:0]);
    pkt_bytes.push_back({h.flags, h.foff[12:8]});
    pkt_bytes.push_back(h.foff[7:0]);
    pkt_bytes.push_back(h.ttl);
    pkt_bytes.push_back(h.proto);
    pkt_bytes.push_back(8'd0);
    pkt_bytes.push_back(8'd0);
    for (int i = 3; i >= 0; i--) pkt_bytes.push_back(h.src[8*i +: 8]);
    for (int i = 3; i >= 0; i--) pkt_bytes.push_back(h.dst[8*i +: 8]);
    for (int i = 20; i < hl; i++) pkt_bytes.push_back(8'($urandom));
    s = 32'd0;
    for (int i = 0; i + 1 < words_end; i += 2) s += {pkt_bytes[i], pkt_bytes[i+1]};
    while (s[31:16] != 16'd0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    ck = ~s[15:0];
    if (h.bad_csum) ck = ck ^ 16'h0101;
    pkt_bytes[10] = ck[15:8];
    pkt_bytes[11] = ck[7:0];
    for (int i = 0; i < plen; i++) pkt_bytes.push_back(8'($urandom));
  endtask

  // Builds a packet whose total length matches its size and sends it whole.
  task automatic send_good(input hdr_fields_t h, input int plen);
    h.total = 16'(int'(h.ihl) * 4 + plen);
    build_packet(h, plen);
    send_packet(pkt_bytes.size());
  endtask

  task automatic test_protocol_classes();
    hdr_fields_t h;
    logic [7:0]  protos[7];
    protos = '{ipv4p_pkg::IP_PROTO_ICMP, ipv4p_pkg::IP_PROTO_IGMP,
               ipv4p_pkg::IP_PROTO_TCP, ipv4p_pkg::IP_PROTO_EGP,
               ipv4p_pkg::IP_PROTO_UDP, 8'd0, 8'd255};
    foreach (protos[i]) begin
      h = random_header();
      h.ihl   = 4'd5;
      h.flags = 3'd0;
      h.foff  = 13'd0;
      h.proto = protos[i];
      // Field extremes ride on the first two packets.
      if (i == 0) begin
        h.src = '0; h.dst = '0; h.tos = '0; h.ident = '0; h.ttl = 8'd1;
      end else if (i == 1) begin
        h.src = '1; h.dst = '1; h.tos = '1; h.ident = '1; h.ttl = 8'd255;
      end
      send_good(h, $urandom_range(0, 4));
    end
  endtask

  task automatic test_length_checks();
    hdr_fields_t h;
    h = random_header();
    h.ihl = 4'd5;
    // A packet of one byte, and a bare 20-byte header: both too short.
    send_good(h, 0);
    pkt_bytes[0] = 8'h45;
    wait_idle();
    build_packet(h, 0);
    send_packet(1);
    send_packet(20);
    // The smallest packet that can pass.
    send_good(h, 1);
    // A 60-byte header cut off after 30 bytes.
    h.ihl   = 4'd15;
    h.total = 16'd70;
    build_packet(h, 10);
    send_packet(30);
    // Largest header, fully delivered.
    send_good(h, 3);
    // Total length larger than what arrives: payload limited by the bytes.
    h.ihl   = 4'd5;
    h.total = 16'd100;
    build_packet(h, 5);
    send_packet(pkt_bytes.size());
    // Total length below the header length.
    h.total = 16'd19;
    build_packet(h, 4);
    send_packet(pkt_bytes.size());
    // Header length field below five words.
    h.ihl = 4'd0;
    send_good(h, 2);
    h.ihl = 4'd4;
    send_good(h, 2);
  endtask

  task automatic test_header_checks();
    hdr_fields_t h;
    h = random_header();
    h.ihl      = 4'd5;
    h.bad_csum = 1'b1;
    send_good(h, 3);
    h.bad_csum = 1'b0;
    h.ttl      = 8'd0;
    send_good(h, 3);
    h.ttl = 8'd64;
    h.ver = 4'd6;
    send_good(h, 3);
    h.ver = 4'd0;
    h.ihl = 4'd15;
    send_good(h, 2);
    // Several failures at once: the first in check order wins.
    h.ver      = 4'd15;
    h.ttl      = 8'd0;
    h.bad_csum = 1'b1;
    send_good(h, 1);
  endtask

  task automatic test_fragments();
    hdr_fields_t h;
    logic [2:0]  flag_set[5];
    logic [12:0] offs[5];
    flag_set = '{3'b001, 3'b000, 3'b010, 3'b100, 3'b111};
    offs     = '{13'd0, 13'h1fff, 13'd0, 13'd0, 13'h1fff};
    foreach (flag_set[i]) begin
      h = random_header();
      h.ihl   = 4'd5;
      h.proto = ipv4p_pkg::IP_PROTO_TCP;
      h.flags = flag_set[i];
      h.foff  = offs[i];
      send_good(h, 2);
    end
  endtask

  task automatic test_checksum_disable();
    hdr_fields_t h;
    set_checksum(1'b0);
    h = random_header();
    h.ihl      = 4'd5;
    h.flags    = 3'd0;
    h.foff     = 13'd0;
    h.proto    = ipv4p_pkg::IP_PROTO_UDP;
    h.bad_csum = 1'b1;
    send_good(h, 4);
    h.ttl = 8'd0;
    send_good(h, 4);
    set_checksum(1'b1);
    h.ttl = 8'd10;
    send_good(h, 4);
  endtask

  // Random packets until the run has sent about ITEM_TARGET bytes in all,
  // and at least RANDOM_PKTS packets.
  task automatic test_random_traffic();
    hdr_fields_t h;
    int          plen;
    int          kind;
    int          cut;
    int          pkts;
    pkts = 0;
    while (sent_bytes < ITEM_TARGET || pkts < RANDOM_PKTS) begin
      if (pkts % 4 == 3) set_checksum(1'($urandom_range(0, 1)));
      // Some packets go through with no idling on either side.
      gaps_on = ($urandom_range(0, 4) != 0);
      h    = random_header();
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 80) : $urandom_range(0, 12);
      h.total = 16'(int'(h.ihl) * 4 + plen);
      kind = $urandom_range(0, 99);
      if (kind < 8) h.total = 16'($urandom);
      else if (kind < 12) h.bad_csum = 1'b1;
      else if (kind < 15) h.ttl = 8'd0;
      else if (kind < 18) h.ver = 4'($urandom);
      else if (kind < 21) h.ihl = 4'($urandom_range(0, 4));
      build_packet(h, plen);
      cut = pkt_bytes.size();
      if (kind >= 88 && kind < 96) begin
        cut = $urandom_range(1, cut);
      end else if (kind >= 96) begin
        pkt_bytes.delete();
        cut = $urandom_range(1, 40);
        for (int i = 0; i < cut; i++) pkt_bytes.push_back(8'($urandom));
      end
      send_packet(cut);
      pkts++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'd0;
    s_tlast   <= 1'b0;
    hp_csum_en = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_protocol_classes();
    test_length_checks();
    test_header_checks();
    test_fragments();
    test_checksum_disable();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
